/* rtl/dshot_pkg.sv */
// ----------------------------------------------------------------------------
// dshot_pkg
// Shared types and constants for the dshot frame transmitter.
// ----------------------------------------------------------------------------
package dshot_pkg;

  localparam int GUARD_SLOTS_DEF = 3;
  localparam int BIT_COUNT       = 16;
  localparam int QUEUE_DEPTH     = 2;

  // one encoded frame: 11-bit value, telemetry bit, 4-bit checksum
  typedef logic [BIT_COUNT-1:0] frame_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

/* rtl/dshot_front.sv */
// ----------------------------------------------------------------------------
// dshot_front
// Accepts motor requests, scales the throttle and builds the frame word.
// ----------------------------------------------------------------------------
module dshot_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [16:0]       in_throttle,
  input  logic [10:0]       in_command,
  input  logic              in_telemetry,
  input  logic              q_full,
  output logic              push,
  output dshot_pkg::frame_t push_frame
);

  localparam logic [15:0] FULL_SCALE = 16'h8000;
  localparam logic [10:0] THR_MUL    = 11'd1999;
  localparam logic [10:0] VALUE_BASE = 11'd48;

  logic        valid_r;
  logic        mode_r;
  logic        neg_r;
  logic        tel_r;
  logic [10:0] cmd_r;
  logic [26:0] prod_r;

  logic [15:0] t_clamped;
  logic        accept;
  logic [10:0] value;
  logic [11:0] word;
  logic [3:0]  csum;

  assign accept   = in_valid && in_ready;
  assign push     = valid_r && !q_full;
  assign in_ready = !valid_r || !q_full;

  // negative throttle is caught by the sign bit, above full clamps to full
  assign t_clamped = (in_throttle[15:0] > FULL_SCALE) ? FULL_SCALE : in_throttle[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (push) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      neg_r  <= in_throttle[16];
      tel_r  <= in_telemetry;
      cmd_r  <= in_command;
      prod_r <= {11'd0, t_clamped} * {16'd0, THR_MUL};
    end
  end

  always_comb begin
    if (mode_r) begin
      value = cmd_r;
      word  = {cmd_r, tel_r};
    end else begin
      value = neg_r ? 11'd0 : (prod_r[25:15] + VALUE_BASE);
      word  = {value, 1'b0};
    end
    csum       = word[3:0] ^ word[7:4] ^ word[11:8];
    push_frame = {word, csum};
  end

endmodule

/* rtl/dshot_queue.sv */
// ----------------------------------------------------------------------------
// dshot_queue
// Short frame queue between the request front end and the slot serializer.
// ----------------------------------------------------------------------------
module dshot_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dshot_pkg::frame_t     push_frame,
  input  logic                  pop,
  output dshot_pkg::frame_t     pop_frame,
  output dshot_pkg::q_status_t  status
);

  localparam int PTR_W = (dshot_pkg::QUEUE_DEPTH > 1) ? $clog2(dshot_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(dshot_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(dshot_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(dshot_pkg::QUEUE_DEPTH - 1);

  dshot_pkg::frame_t entries_r [dshot_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r,  count_nxt;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == DEPTH_C);
  assign pop_frame    = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_P) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_P) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_frame;
    end
  end

endmodule

/* rtl/dshot_serializer.sv */
// ----------------------------------------------------------------------------
// dshot_serializer
// Walks a frame out as line slots: guard, high/bit/low per bit, guard.
// ----------------------------------------------------------------------------
module dshot_serializer #(
  parameter int GUARD_SLOTS = dshot_pkg::GUARD_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dshot_pkg::q_status_t  q_status,
  input  dshot_pkg::frame_t     q_frame,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_level,
  output logic                  out_last
);

  localparam int FRAME_SLOTS = 2 * GUARD_SLOTS + 3 * dshot_pkg::BIT_COUNT;
  localparam int SLOT_W      = $clog2(FRAME_SLOTS);
  localparam logic [SLOT_W-1:0] DATA_FIRST = SLOT_W'(GUARD_SLOTS);
  localparam logic [SLOT_W-1:0] DATA_END   = SLOT_W'(GUARD_SLOTS + 3 * dshot_pkg::BIT_COUNT);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(FRAME_SLOTS - 1);

  logic              busy_r,  busy_nxt;
  logic [SLOT_W-1:0] slot_r,  slot_nxt;
  logic [1:0]        phase_r, phase_nxt;
  dshot_pkg::frame_t shift_r, shift_nxt;
  logic              valid_r, valid_nxt;
  logic              level_r, level_nxt;
  logic              last_r,  last_nxt;

  logic can_issue;
  logic in_data;
  logic level;
  logic is_last;

  assign out_valid = valid_r;
  assign out_level = level_r;
  assign out_last  = last_r;
  assign can_issue = !valid_r || out_ready;
  assign in_data   = (slot_r >= DATA_FIRST) && (slot_r < DATA_END);
  assign is_last   = (slot_r == LAST_SLOT);

  always_comb begin
    level = 1'b0;
    if (in_data) begin
      case (phase_r)
        2'd0:    level = 1'b1;
        2'd1:    level = shift_r[dshot_pkg::BIT_COUNT-1];
        default: level = 1'b0;
      endcase
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    slot_nxt  = slot_r;
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    valid_nxt = valid_r && !out_ready;
    level_nxt = level_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (busy_r && can_issue) begin
      valid_nxt = 1'b1;
      level_nxt = level;
      last_nxt  = is_last;
      slot_nxt  = slot_r + 1'b1;
      if (in_data) begin
        phase_nxt = (phase_r == 2'd2) ? 2'd0 : phase_r + 2'd1;
        if (phase_r == 2'd2) begin
          shift_nxt = {shift_r[dshot_pkg::BIT_COUNT-2:0], 1'b0};
        end
      end
      if (is_last) begin
        // back to back frames: pick up the next one as this one ends
        busy_nxt  = !q_status.empty;
        pop       = !q_status.empty;
        slot_nxt  = '0;
        phase_nxt = 2'd0;
        shift_nxt = q_status.empty ? shift_r : q_frame;
      end
    end else if (!busy_r && !q_status.empty) begin
      pop       = 1'b1;
      busy_nxt  = 1'b1;
      slot_nxt  = '0;
      phase_nxt = 2'd0;
      shift_nxt = q_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      slot_r  <= '0;
      phase_r <= 2'd0;
      shift_r <= '0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      slot_r  <= slot_nxt;
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    last_r  <= last_nxt;
  end

endmodule

/* rtl/dshot_frame_transmitter.sv */
// ----------------------------------------------------------------------------
// dshot_frame_transmitter
// Motor request to dshot line slots: scale, checksum, queue, serialize.
// ----------------------------------------------------------------------------
// path: front request register, queue entry, serializer shift and output registers
// throughput: one slot per cycle unless out_tready stalls; 2*GUARD_SLOTS+48 slots
//   per frame (54 at default) by the serializer; queued frames follow with no gap
// a two-entry frame queue lets requests be taken while a frame is sent
// reset: synchronous active low, clears the queue and all valid state
module dshot_frame_transmitter #(
  parameter int GUARD_SLOTS = dshot_pkg::GUARD_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // throttle[16:0], command[27:17], telemetry[28]
  input  logic        in_tuser,   // mode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // line_level[0]
  output logic        out_tlast
);

  logic                 push;
  logic                 pop;
  dshot_pkg::frame_t    push_frame;
  dshot_pkg::frame_t    pop_frame;
  dshot_pkg::q_status_t q_status;
  logic                 level;

  dshot_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_mode      (in_tuser),
    .in_throttle  (in_tdata[16:0]),
    .in_command   (in_tdata[27:17]),
    .in_telemetry (in_tdata[28]),
    .q_full       (q_status.full),
    .push         (push),
    .push_frame   (push_frame)
  );

  dshot_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .pop_frame  (pop_frame),
    .status     (q_status)
  );

  dshot_serializer #(
    .GUARD_SLOTS (GUARD_SLOTS)
  ) u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_frame   (pop_frame),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_level (level),
    .out_last  (out_tlast)
  );

  assign out_tdata = {7'd0, level};

endmodule

/* verif/dshot_frame_transmitter_tb.sv */
// ----------------------------------------------------------------------------
// dshot_frame_transmitter_tb
// Drives motor requests in throttle and command mode into the transmitter and
// checks every line slot of every frame against a locally built frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dshot_frame_transmitter_tb;

  localparam int FRAME_SLOTS = 2 * dshot_pkg::GUARD_SLOTS_DEF + 3 * dshot_pkg::BIT_COUNT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 70;

  typedef struct packed {
    logic line_level;
    logic last_slot;
  } slot_t;

  class slot_scoreboard;
    slot_t slots_q[$];
    int errors = 0;

    // builds the frame for one accepted request and queues its line slots
    function void note_request(logic mode, logic [16:0] throttle, logic [10:0] command,
                               logic telemetry);
      logic [16:0] t;
      logic [31:0] prod;
      logic [10:0] value;
      logic tel;
      logic [11:0] word;
      dshot_pkg::frame_t frame;
      slot_t s;
      if (mode) begin
        value = command;
        tel = telemetry;
      end else begin
        tel = 1'b0;
        if (throttle[16]) begin
          value = 11'd0;
        end else begin
          t = (throttle > 17'h08000) ? 17'h08000 : throttle;
          prod = 32'(t) * 32'd1999;
          value = 11'(32'd48 + (prod >> 15));
        end
      end
      word = {value, tel};
      frame = {word, word[3:0] ^ word[7:4] ^ word[11:8]};
      s.last_slot = 1'b0;
      s.line_level = 1'b0;
      for (int i = 0; i < dshot_pkg::GUARD_SLOTS_DEF; i++) slots_q.push_back(s);
      for (int b = dshot_pkg::BIT_COUNT - 1; b >= 0; b--) begin
        s.line_level = 1'b1;
        slots_q.push_back(s);
        s.line_level = frame[b];
        slots_q.push_back(s);
        s.line_level = 1'b0;
        slots_q.push_back(s);
      end
      for (int i = 0; i < dshot_pkg::GUARD_SLOTS_DEF; i++) begin
        s.last_slot = (i == dshot_pkg::GUARD_SLOTS_DEF - 1);
        slots_q.push_back(s);
      end
    endfunction

    function void check_slot(logic line_level, logic last_slot);
      slot_t exp_s;
      if (slots_q.size() == 0) begin
        $display("%0t: unexpected slot transfer, level %b last %b", $time,
                 line_level, last_slot);
        errors++;
        return;
      end
      exp_s = slots_q.pop_front();
      if (line_level !== exp_s.line_level) begin
        $display("%0t: line_level mismatch, expected %b actual %b", $time,
                 exp_s.line_level, line_level);
        errors++;
      end
      if (last_slot !== exp_s.last_slot) begin
        $display("%0t: last_slot mismatch, expected %b actual %b", $time,
                 exp_s.last_slot, last_slot);
        errors++;
      end
    endfunction

    function int pending();
      return slots_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // throttle[16:0], command[27:17], telemetry[28]
  logic        in_tuser = 1'b0; // mode[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // line_level[0]
  logic        out_tlast;

  slot_scoreboard sb = new();
  int tx_idle_pct = 24;
  int rx_stall_pct = 46;
  int cycles = 0;

  dshot_frame_transmitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: check each slot transfer, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_slot(out_tdata[0], out_tlast);
    out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  task automatic send_request(logic mode, logic [16:0] throttle, logic [10:0] command,
                              logic telemetry);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {3'b000, telemetry, command, throttle};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(mode, throttle, command, telemetry);
  endtask

  task automatic wait_frames_done();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random();
    logic [16:0] thr;
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 5))
      0: thr = 17'h08000 + 17'($signed($urandom_range(0, 16)) - 8);
      1: thr = 17'($urandom_range(0, 64));
      2: thr = 17'h10000 | 17'($urandom_range(0, 65535));
      3: thr = 17'($urandom_range(0, 32768));
      default: thr = r[16:0];
    endcase
    send_request(1'($urandom_range(0, 1)), thr, 11'($urandom_range(0, 2047)),
                 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // throttle extremes, clamping and the negative case
    send_request(1'b0, 17'd0, 11'd0, 1'b0);
    send_request(1'b0, 17'd1, 11'd0, 1'b0);
    send_request(1'b0, 17'd21, 11'd0, 1'b0);
    send_request(1'b0, 17'd16384, 11'd0, 1'b0);
    send_request(1'b0, 17'd32767, 11'd0, 1'b0);
    send_request(1'b0, 17'd32768, 11'd0, 1'b0);
    send_request(1'b0, 17'd32769, 11'd0, 1'b0);
    send_request(1'b0, 17'd65535, 11'd0, 1'b0);
    send_request(1'b0, 17'h1FFFF, 11'd0, 1'b0);
    send_request(1'b0, 17'h10000, 11'd0, 1'b0);
    // command and telemetry must not leak into a throttle frame
    send_request(1'b0, 17'd0, 11'd2047, 1'b1);
    send_request(1'b0, 17'd32768, 11'h555, 1'b1);
    // command mode, throttle field ignored
    send_request(1'b1, 17'd0, 11'd0, 1'b0);
    send_request(1'b1, 17'd0, 11'd0, 1'b1);
    send_request(1'b1, 17'd0, 11'd2047, 1'b0);
    send_request(1'b1, 17'd0, 11'd2047, 1'b1);
    send_request(1'b1, 17'h1FFFF, 11'd1, 1'b0);
    send_request(1'b1, 17'd65535, 11'h555, 1'b0);
    send_request(1'b1, 17'h10000, 11'h2AA, 1'b1);
    send_request(1'b1, 17'd32768, 11'd48, 1'b1);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          tx_idle_pct = 24;
          rx_stall_pct = 46;
        end
        1: begin
          tx_idle_pct = 46;
          rx_stall_pct = 24;
        end
        default: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random();
      // hold off the sender until the output has caught up
      if (p == 0) wait_frames_done();
    end

    wait_frames_done();
    repeat (FRAME_SLOTS + 10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
